// ----- design/brr_pkg.sv -----
// Package for the HTTP byte range resolver.
// Holds the result kind codes and the character constants of the parser.
// No dependencies.
package brr_pkg;

    typedef logic [1:0] t_kind;

    localparam t_kind KIND_FULL    = 2'd0;
    localparam t_kind KIND_PARTIAL = 2'd1;
    localparam t_kind KIND_UNSAT   = 2'd2;

    localparam int unsigned PREFIX_LEN = 6;

    typedef logic [7:0] t_char;
    typedef logic [2:0] t_prefix_idx;

    localparam t_char CHAR_DASH  = 8'h2D;
    localparam t_char CHAR_COMMA = 8'h2C;
    localparam t_char CHAR_ZERO  = 8'h30;
    localparam t_char CHAR_NINE  = 8'h39;

    // The literal "bytes=", one character per position.
    localparam t_char PREFIX_TEXT [PREFIX_LEN] = '{8'h62, 8'h79, 8'h74, 8'h65, 8'h73, 8'h3D};

endpackage

// ----- design/brr_if.sv -----
// Handshake channels of the HTTP byte range resolver: header characters in,
// resolutions out. Depends on brr_pkg for the character and kind types.
interface brr_in_if #(
    parameter int unsigned VALUE_WIDTH = 64
);
    logic                   valid;
    logic                   ready;
    brr_pkg::t_char         header_byte;
    logic                   no_byte;
    logic                   is_last;
    logic [VALUE_WIDTH-1:0] resource_size;

    modport source (output valid, header_byte, no_byte, is_last, resource_size, input ready);
    modport sink   (input valid, header_byte, no_byte, is_last, resource_size, output ready);
endinterface

interface brr_out_if #(
    parameter int unsigned VALUE_WIDTH = 64
);
    logic                   valid;
    logic                   ready;
    brr_pkg::t_kind         range_kind;
    logic [VALUE_WIDTH-1:0] range_start;
    logic [VALUE_WIDTH-1:0] range_length;

    modport source (output valid, range_kind, range_start, range_length, input ready);
    modport sink   (input valid, range_kind, range_start, range_length, output ready);
endinterface

// ----- design/http_byte_range_resolver_top.sv -----
// Top level of the HTTP byte range resolver.
// Depends on brr_pkg and on the channel interfaces in brr_if.sv.
//
// The block takes one character of a Range header value per word, in every
// cycle, and on the word marked is_last delivers one result word: full,
// partial or unsatisfiable, with start and length. The parse state is updated
// as each word is accepted; the resolution against resource_size is worked
// out from the parse registers into the output register once that register
// is free to take it. A new header may start in the very next word. Input is
// stalled only during reset, or while a finished result is held in the output
// register and a second one is waiting behind it, and for as long as the
// output is not taken.
module http_byte_range_resolver_top #(
    parameter int unsigned VALUE_WIDTH = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    brr_in_if.sink    i_item,
    brr_out_if.source o_result
);
    import brr_pkg::*;

    localparam int unsigned VW = VALUE_WIDTH;

    typedef struct packed {
        t_prefix_idx   prefix_count;
        logic          prefix_mismatch;
        logic          dash_seen;
        logic          comma_seen;
        logic [VW-1:0] start_value;
        logic          start_has_digits;
        logic          start_malformed;
        logic [VW-1:0] end_value;
        logic          end_has_digits;
        logic          end_malformed;
    } t_parse_state;

    t_parse_state  r_state, n_state, base_state;
    logic          r_fin;
    logic [VW-1:0] r_size;
    logic          r_out_valid;
    t_kind         r_kind;
    logic [VW-1:0] r_start;
    logic [VW-1:0] r_length;

    logic          out_blocked;
    logic          fire_res;
    logic          accept;
    t_char         chr;
    logic          is_digit;
    logic [VW-1:0] digit_val;

    t_kind         res_kind;
    logic [VW-1:0] res_start;
    logic [VW-1:0] res_length;

    assign out_blocked  = r_out_valid && !o_result.ready;
    assign fire_res     = r_fin && !out_blocked;
    assign i_item.ready = i_rst_n && !(r_fin && out_blocked);
    assign accept       = i_item.valid && i_item.ready;

    assign chr       = i_item.header_byte;
    assign is_digit  = (chr >= CHAR_ZERO) && (chr <= CHAR_NINE);
    assign digit_val = VW'(chr[3:0]);

    // Parse update for one word. When a result leaves this cycle the word
    // belongs to the next header, so it starts from a cleared state.
    always_comb begin
        base_state = fire_res ? '0 : r_state;
        n_state    = base_state;
        if (!i_item.no_byte && !base_state.prefix_mismatch) begin
            if (base_state.prefix_count < t_prefix_idx'(PREFIX_LEN)) begin
                if (chr != PREFIX_TEXT[base_state.prefix_count]) begin
                    n_state.prefix_mismatch = 1'b1;
                end
                n_state.prefix_count = base_state.prefix_count + 3'd1;
            end else begin
                if (chr == CHAR_COMMA) begin
                    n_state.comma_seen = 1'b1;
                end
                if (!base_state.dash_seen) begin
                    if (chr == CHAR_DASH) begin
                        n_state.dash_seen = 1'b1;
                    end else if (is_digit) begin
                        n_state.start_value = {base_state.start_value[VW-4:0], 3'b000}
                                            + {base_state.start_value[VW-2:0], 1'b0}
                                            + digit_val;
                        n_state.start_has_digits = 1'b1;
                    end else begin
                        n_state.start_malformed = 1'b1;
                    end
                end else begin
                    if (is_digit) begin
                        n_state.end_value = {base_state.end_value[VW-4:0], 3'b000}
                                          + {base_state.end_value[VW-2:0], 1'b0}
                                          + digit_val;
                        n_state.end_has_digits = 1'b1;
                    end else begin
                        n_state.end_malformed = 1'b1;
                    end
                end
            end
        end
    end

    // Resolution of the completed header against the sampled size.
    logic          start_empty;
    logic          end_empty;
    logic [VW-1:0] size_last;
    logic [VW-1:0] last_idx;
    logic [VW-1:0] suffix_n;

    always_comb begin
        start_empty = !r_state.start_has_digits && !r_state.start_malformed;
        end_empty   = !r_state.end_has_digits && !r_state.end_malformed;
        size_last   = r_size - VW'(1);
        last_idx    = (!end_empty && (r_state.end_value < size_last)) ?
                      r_state.end_value : size_last;
        suffix_n    = (r_state.end_value < r_size) ? r_state.end_value : r_size;

        res_kind   = KIND_FULL;
        res_start  = '0;
        res_length = r_size;

        if (r_state.prefix_count < t_prefix_idx'(PREFIX_LEN) || r_state.prefix_mismatch ||
            r_state.comma_seen || !r_state.dash_seen) begin
            res_kind = KIND_FULL;
        end else if (r_size == '0) begin
            res_kind   = KIND_UNSAT;
            res_length = '0;
        end else if (start_empty) begin
            // Suffix form: the last N bytes.
            if (end_empty || r_state.end_malformed) begin
                res_kind = KIND_FULL;
            end else if (r_state.end_value == '0) begin
                res_kind   = KIND_UNSAT;
                res_length = '0;
            end else begin
                res_kind   = KIND_PARTIAL;
                res_start  = r_size - suffix_n;
                res_length = suffix_n;
            end
        end else if (r_state.start_malformed) begin
            res_kind = KIND_FULL;
        end else if (r_state.start_value >= r_size) begin
            res_kind   = KIND_UNSAT;
            res_length = '0;
        end else if (!end_empty && r_state.end_malformed) begin
            res_kind = KIND_FULL;
        end else if (last_idx < r_state.start_value) begin
            res_kind   = KIND_UNSAT;
            res_length = '0;
        end else begin
            res_kind   = KIND_PARTIAL;
            res_start  = r_state.start_value;
            res_length = last_idx - r_state.start_value + VW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
            r_fin   <= 1'b0;
        end else if (accept) begin
            r_state <= n_state;
            r_fin   <= i_item.is_last;
        end else if (fire_res) begin
            r_state <= '0;
            r_fin   <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_size <= i_item.resource_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire_res) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire_res) begin
            r_kind   <= res_kind;
            r_start  <= res_start;
            r_length <= res_length;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.range_kind   = r_kind;
    assign o_result.range_start  = r_start;
    assign o_result.range_length = r_length;

endmodule
